// ===== hdl/wpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the wink pattern detector.
// No dependencies; every other file of the block refers to this package.

package wpd_pkg;

   localparam int EYE_COUNT_W = 4;
   localparam int CFG_W       = 4;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // History entry codes.
   localparam logic [1:0] CODE_ONE  = 2'd1;
   localparam logic [1:0] CODE_TWO  = 2'd2;
   localparam logic [1:0] CODE_MANY = 2'd3;

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_OPEN_MIN = 2'd0;
   localparam logic [1:0] REG_OPEN_MAX = 2'd1;
   localparam logic [1:0] REG_WINK_MIN = 2'd2;
   localparam logic [1:0] REG_WINK_MAX = 2'd3;

   // Register reset values.
   localparam logic [CFG_W-1:0] OPEN_MIN_RST = 4'd3;
   localparam logic [CFG_W-1:0] OPEN_MAX_RST = 4'd12;
   localparam logic [CFG_W-1:0] WINK_MIN_RST = 4'd1;
   localparam logic [CFG_W-1:0] WINK_MAX_RST = 4'd7;

   typedef struct packed {
      logic [CFG_W-1:0] open_run_min_excl;
      logic [CFG_W-1:0] open_run_max_excl;
      logic [CFG_W-1:0] wink_run_min_excl;
      logic [CFG_W-1:0] wink_run_max_excl;
   } wpd_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_REPORT = 4'b1000
   } wpd_state_type;

   // Which run the scan is measuring.
   typedef enum logic [1:0] {
      PH_OPEN_A = 2'd0,
      PH_WINK   = 2'd1,
      PH_OPEN_B = 2'd2
   } wpd_phase_type;

   typedef struct packed {
      logic update;
      logic scan_start;
      logic report;
   } wpd_cmd_type;

   typedef struct packed {
      logic full;
      logic scan_done;
      logic match;
      logic out_free;
   } wpd_status_type;

endpackage

// ===== hdl/wpd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response beats.
// Depends on wpd_pkg for the field widths.

interface wpd_req_if;
   logic                            valid;
   logic                            ready;
   logic [wpd_pkg::EYE_COUNT_W-1:0] eye_count;

   modport source (output valid, output eye_count, input ready);
   modport sink   (input valid, input eye_count, output ready);
endinterface

interface wpd_rsp_if;
   logic valid;
   logic ready;
   logic wink_seen;

   modport source (output valid, output wink_seen, input ready);
   modport sink   (input valid, input wink_seen, output ready);
endinterface

// ===== hdl/wpd_csr.sv =====
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on wpd_pkg.

module wpd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [wpd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [wpd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [wpd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output wpd_pkg::wpd_cfg_type           cfg
);

   wpd_pkg::wpd_cfg_type cfg_ff;
   logic [1:0]           reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_run_min_excl <= wpd_pkg::OPEN_MIN_RST;
         cfg_ff.open_run_max_excl <= wpd_pkg::OPEN_MAX_RST;
         cfg_ff.wink_run_min_excl <= wpd_pkg::WINK_MIN_RST;
         cfg_ff.wink_run_max_excl <= wpd_pkg::WINK_MAX_RST;
      end else if (wr_en) begin
         case (reg_idx)
            wpd_pkg::REG_OPEN_MIN: cfg_ff.open_run_min_excl <= pwdata[wpd_pkg::CFG_W-1:0];
            wpd_pkg::REG_OPEN_MAX: cfg_ff.open_run_max_excl <= pwdata[wpd_pkg::CFG_W-1:0];
            wpd_pkg::REG_WINK_MIN: cfg_ff.wink_run_min_excl <= pwdata[wpd_pkg::CFG_W-1:0];
            wpd_pkg::REG_WINK_MAX: cfg_ff.wink_run_max_excl <= pwdata[wpd_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         wpd_pkg::REG_OPEN_MIN: prdata[wpd_pkg::CFG_W-1:0] = cfg_ff.open_run_min_excl;
         wpd_pkg::REG_OPEN_MAX: prdata[wpd_pkg::CFG_W-1:0] = cfg_ff.open_run_max_excl;
         wpd_pkg::REG_WINK_MIN: prdata[wpd_pkg::CFG_W-1:0] = cfg_ff.wink_run_min_excl;
         wpd_pkg::REG_WINK_MAX: prdata[wpd_pkg::CFG_W-1:0] = cfg_ff.wink_run_max_excl;
         default: prdata = '0;
      endcase
   end

endmodule

// ===== hdl/wpd_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine: accept, start scan, wait, hand the result over.
// Depends on wpd_pkg.

module wpd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wpd_pkg::wpd_status_type status,
   output wpd_pkg::wpd_cmd_type    cmd
);

   wpd_pkg::wpd_state_type state_ff;
   wpd_pkg::wpd_state_type state_in;

   assign req_ready = (state_ff == wpd_pkg::ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd.update     = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.report     = 1'b0;
      case (state_ff)
         wpd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.update = 1'b1;
               state_in   = wpd_pkg::ST_CHECK;
            end
         end
         wpd_pkg::ST_CHECK: begin
            cmd.scan_start = 1'b1;
            state_in       = wpd_pkg::ST_SCAN;
         end
         wpd_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = wpd_pkg::ST_REPORT;
            end
         end
         wpd_pkg::ST_REPORT: begin
            // Hold until the output register is free.
            if (status.out_free) begin
               cmd.report = 1'b1;
               state_in   = wpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wpd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/wpd_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: circular history memory, fill tracking, run-length scan unit
// and the response register. Depends on wpd_pkg.

module wpd_dpath #(
   parameter int WINDOW_LEN = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  wpd_pkg::wpd_cmd_type            cmd,
   output wpd_pkg::wpd_status_type         status,
   input  wpd_pkg::wpd_cfg_type            cfg,
   input  logic [wpd_pkg::EYE_COUNT_W-1:0] eye_count,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_wink_seen
);

   localparam int PW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CW = $clog2(WINDOW_LEN + 1);
   localparam int SW = PW + 1;
   localparam int BW = (CW > wpd_pkg::CFG_W) ? CW : wpd_pkg::CFG_W;
   localparam logic [CW-1:0] FULL_LVL = CW'(WINDOW_LEN);
   localparam logic [CW-1:0] LAST_LVL = CW'(WINDOW_LEN - 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(WINDOW_LEN - 1);
   localparam logic [SW-1:0] WRAP_SUM = SW'(WINDOW_LEN);

   function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [SW-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= WRAP_SUM) begin
         s = s - WRAP_SUM;
      end
      return s[PW-1:0];
   endfunction

   function automatic logic in_bounds(input logic [CW-1:0] len,
                                      input logic [wpd_pkg::CFG_W-1:0] lo,
                                      input logic [wpd_pkg::CFG_W-1:0] hi);
      logic [BW-1:0] l;
      l = BW'(len);
      return (l > BW'(lo)) && (l < BW'(hi));
   endfunction

   logic [1:0]            hist_mem [WINDOW_LEN];
   logic [1:0]            rd_data_ff;
   logic [PW-1:0]         head_ff;
   logic [CW-1:0]         fill_ff;
   logic                  scan_active_ff;
   logic                  rd_valid_ff;
   logic [CW-1:0]         issue_ff;
   logic [CW-1:0]         eval_ff;
   wpd_pkg::wpd_phase_type phase_ff;
   logic [CW-1:0]         run_ff;
   logic                  match_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_wink_ff;

   // Update path.
   logic                  full;
   logic [PW-1:0]         head_in;
   logic [CW-1:0]         fill_drop;
   logic [CW-1:0]         fill_in;
   logic [PW-1:0]         wr_addr;
   logic                  wr_en;
   logic [1:0]            wr_code;
   logic [PW-1:0]         rd_addr;
   logic                  issue_go;

   // Scan evaluation.
   logic [1:0]            exp_code;
   wpd_pkg::wpd_phase_type phase_in;
   logic [CW-1:0]         run_in;
   logic                  finish;
   logic                  win;

   assign full = (fill_ff == FULL_LVL);

   always_comb begin
      if (full) begin
         head_in   = (head_ff == LAST_PTR) ? '0 : head_ff + PW'(1);
         fill_drop = fill_ff - CW'(1);
      end else begin
         head_in   = head_ff;
         fill_drop = fill_ff;
      end
      wr_addr = wrap_add(head_in, fill_drop[PW-1:0]);
      wr_en   = cmd.update && (eye_count != '0);
      wr_code = (eye_count >= wpd_pkg::EYE_COUNT_W'(3)) ? wpd_pkg::CODE_MANY : eye_count[1:0];
      fill_in = wr_en ? fill_drop + CW'(1) : fill_drop;
   end

   assign issue_go = scan_active_ff && (issue_ff < FULL_LVL);
   assign rd_addr  = wrap_add(head_ff, issue_ff[PW-1:0]);

   always_comb begin
      exp_code = (phase_ff == wpd_pkg::PH_WINK) ? wpd_pkg::CODE_ONE : wpd_pkg::CODE_TWO;
      phase_in = phase_ff;
      run_in   = run_ff;
      finish   = 1'b0;
      win      = 1'b0;
      if (rd_data_ff == exp_code) begin
         run_in = run_ff + CW'(1);
      end else begin
         case (phase_ff)
            wpd_pkg::PH_OPEN_A: begin
               if (rd_data_ff == wpd_pkg::CODE_ONE &&
                   in_bounds(run_ff, cfg.open_run_min_excl, cfg.open_run_max_excl)) begin
                  phase_in = wpd_pkg::PH_WINK;
                  run_in   = CW'(1);
               end else begin
                  finish = 1'b1;
               end
            end
            wpd_pkg::PH_WINK: begin
               if (rd_data_ff == wpd_pkg::CODE_TWO &&
                   in_bounds(run_ff, cfg.wink_run_min_excl, cfg.wink_run_max_excl)) begin
                  phase_in = wpd_pkg::PH_OPEN_B;
                  run_in   = CW'(1);
               end else begin
                  finish = 1'b1;
               end
            end
            wpd_pkg::PH_OPEN_B: begin
               finish = 1'b1;
               win    = in_bounds(run_ff, cfg.open_run_min_excl, cfg.open_run_max_excl);
            end
            default: begin
               finish = 1'b1;
            end
         endcase
      end
      // The last entry closes whatever run is open.
      if (!finish && (eval_ff == LAST_LVL)) begin
         finish = 1'b1;
         win    = (phase_in == wpd_pkg::PH_OPEN_B) &&
                  in_bounds(run_in, cfg.open_run_min_excl, cfg.open_run_max_excl);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_code;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         fill_ff        <= '0;
         scan_active_ff <= 1'b0;
         rd_valid_ff    <= 1'b0;
         issue_ff       <= '0;
         eval_ff        <= '0;
         phase_ff       <= wpd_pkg::PH_OPEN_A;
         run_ff         <= '0;
         match_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.update) begin
            head_ff <= head_in;
            fill_ff <= fill_in;
         end else if (cmd.report && match_ff) begin
            fill_ff <= '0;
         end

         if (cmd.scan_start) begin
            scan_active_ff <= full;
            rd_valid_ff    <= 1'b0;
            issue_ff       <= '0;
            eval_ff        <= '0;
            phase_ff       <= wpd_pkg::PH_OPEN_A;
            run_ff         <= '0;
            match_ff       <= 1'b0;
         end else if (scan_active_ff) begin
            // A finishing entry stops the read pipeline as well.
            rd_valid_ff <= issue_go && !(rd_valid_ff && finish);
            if (issue_go) begin
               issue_ff <= issue_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               if (finish) begin
                  scan_active_ff <= 1'b0;
                  match_ff       <= win;
               end else begin
                  phase_ff <= phase_in;
                  run_ff   <= run_in;
                  eval_ff  <= eval_ff + CW'(1);
               end
            end
         end

         if (cmd.report) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_wink_ff <= match_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_wink_seen = rsp_wink_ff;

   assign status.full      = full;
   assign status.scan_done = !scan_active_ff;
   assign status.match     = match_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

// ===== hdl/wink_pattern_detector_core.sv =====
`timescale 1ns / 1ps
// Wink pattern detector top level: register file, controller and datapath.
// The response beat is offered once the controller has stepped through accept, scan
// start, scan and report; a full window is scanned with one memory read per entry.
// A new request beat is accepted only after the previous item has been reported.
// Reset (synchronous, active high) empties the history and loads the register defaults.
// Depends on wpd_pkg, wpd_if, wpd_csr, wpd_ctrl and wpd_dpath.

module wink_pattern_detector_core #(
   parameter int WINDOW_LEN = 14
) (
   input  logic                           clock,
   input  logic                           reset,
   wpd_req_if.sink                        req,
   wpd_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [wpd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [wpd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [wpd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   // The history is a circular buffer in a small memory: a head pointer marks
   // the oldest entry and a fill level counts valid entries. Dropping the
   // oldest entry only moves the head, so a sliding window costs at most one
   // write per beat. Entries beyond the fill level are never read, so the
   // memory needs no clearing after reset or after a wink.
   //
   // When the window is full the scan unit walks it oldest first, one entry
   // per cycle, measuring three runs in turn: both eyes, one eye, both eyes.
   // Each run closes as soon as a different code appears, and its length is
   // checked against the exclusive bounds right there; a failed check ends
   // the scan early with no match.
   //
   // The response sits in an output register, so a pending response beat
   // does not stop the next request beat from being accepted.

   wpd_pkg::wpd_cfg_type    cfg;
   wpd_pkg::wpd_cmd_type    cmd;
   wpd_pkg::wpd_status_type status;

   wpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wpd_dpath #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cfg           (cfg),
      .eye_count     (req.eye_count),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_wink_seen (rsp.wink_seen)
   );

`ifndef NO_ASSERTIONS
   // A new response is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.report |-> status.out_free)
      else $error("response loaded while previous beat pending");

   // Only one item is in work at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while an item is in work");

   // A reported wink empties the history.
   a_clear_on_wink: assert property (@(posedge clock) disable iff (reset)
      (cmd.report && status.match) |=> !status.full)
      else $error("history not emptied after wink");

   // Every report follows a completed scan.
   a_report_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.report |-> status.scan_done)
      else $error("report issued while scan still running");
`endif

endmodule
